// ===== rtl/divisor_sum_of_power_mod_prime_macros.svh =====
// Assertion macros shared by the checker of the divisor sum block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DIVISOR_SUM_OF_POWER_MOD_PRIME_MACROS_SVH
`define DIVISOR_SUM_OF_POWER_MOD_PRIME_MACROS_SVH

// Plain property check.
`define DSPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dspm_pkg.sv =====
// Package of the divisor sum block: constants, operation codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package dspm_pkg;

    localparam int DEF_PRIME_TABLE_DEPTH = 8192;
    localparam int DEF_VALUE_WIDTH       = 32;

    localparam int          MODW    = 30;
    localparam logic [29:0] MODULUS = 30'd1000000007;
    localparam int          EXPW    = 38;
    localparam int          CNTW    = 6;
    localparam int          PRIMEW  = 16;
    localparam int          SIEVE_AW   = 16;
    localparam int          SIEVE_ROOT = 256;

    // Datapath operations.
    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_CLR       = 5'd1;
    localparam logic [4:0] OP_FLAG_RD   = 5'd2;
    localparam logic [4:0] OP_ADD_PRIME = 5'd3;
    localparam logic [4:0] OP_MARK      = 5'd4;
    localparam logic [4:0] OP_NEXT_I    = 5'd5;
    localparam logic [4:0] OP_LOAD      = 5'd6;
    localparam logic [4:0] OP_ZERO_PROD = 5'd7;
    localparam logic [4:0] OP_TBL_RD    = 5'd8;
    localparam logic [4:0] OP_LOAD_P    = 5'd9;
    localparam logic [4:0] OP_DIV_GO    = 5'd10;
    localparam logic [4:0] OP_DIV_TAKE  = 5'd11;
    localparam logic [4:0] OP_NEXT_K    = 5'd12;
    localparam logic [4:0] OP_SET_FACT  = 5'd13;
    localparam logic [4:0] OP_SET_LEFT  = 5'd14;
    localparam logic [4:0] OP_MM_GO     = 5'd15;
    localparam logic [4:0] OP_G_ONE     = 5'd16;
    localparam logic [4:0] OP_G_INC     = 5'd17;
    localparam logic [4:0] OP_POW_NUM   = 5'd18;
    localparam logic [4:0] OP_POW_SHIFT = 5'd19;
    localparam logic [4:0] OP_NUM_INV   = 5'd20;
    localparam logic [4:0] OP_OUT       = 5'd21;

    // Operand and destination pairs of the modular multiplier.
    localparam logic [2:0] MM_P1 = 3'd0;  // p * 1 -> residue of p
    localparam logic [2:0] MM_FM = 3'd1;  // f * m -> series factor
    localparam logic [2:0] MM_AB = 3'd2;  // acc * b -> acc
    localparam logic [2:0] MM_BB = 3'd3;  // b * b -> b
    localparam logic [2:0] MM_NI = 3'd4;  // num * inverse -> series factor
    localparam logic [2:0] MM_PG = 3'd5;  // product * factor -> product

    typedef struct packed {
        logic [4:0] op;
        logic [2:0] mm_sel;
    } t_cmd;

    typedef struct packed {
        logic i_last;
        logic i_small;
        logic flag_q;
        logic mark_end;
        logic tbl_end;
        logic sq_gt;
        logic rem_zero;
        logic m_zero;
        logic rem_gt1;
        logic div_done;
        logic div_zero;
        logic cnt_zero;
        logic mm_done;
        logic r_is1;
        logic r_is0;
        logic e_zero;
        logic e_lsb;
    } t_stat;

endpackage

// ===== rtl/dspm_mulmod.sv =====
// Modular multiplier: one registered 32x32 product, then a pipelined
// Barrett reduction modulo the prime. Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_mulmod import dspm_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [31:0]     i_a,
    input  logic [31:0]     i_b,
    output logic            o_done,
    output logic [MODW-1:0] o_res
);

    localparam int PW = 64;
    // Reciprocal floor(2^60 / modulus); every product fed here is below 2^60.
    localparam logic [30:0] MU   = 31'((64'd1 << 60) / 64'(MODULUS));
    localparam logic [31:0] MOD1 = 32'(MODULUS);
    localparam logic [31:0] MOD2 = MOD1 + MOD1;

    logic [PW-1:0]   r_x;
    logic [30:0]     r_q;
    logic [31:0]     r_t;
    logic [MODW-1:0] r_acc;
    logic [2:0]      r_stage;
    logic            r_done;
    logic [PW-1:0]   w_prod;
    logic [61:0]     w_qmu;
    logic [31:0]     w_qm;
    logic [MODW-1:0] w_red;

    // Full product of the operands.
    assign w_prod = i_a * i_b;

    // Quotient estimate, its low product with the modulus, and the final
    // correction: the estimate is short by at most two, so the remainder
    // is below three times the modulus and fits in 32 bits.
    always_comb begin
        w_qmu = 62'(r_x[59:29]) * 62'(MU);
        w_qm  = 32'(r_q) * MOD1;
        if (r_t >= MOD2) begin
            w_red = MODW'(r_t - MOD2);
        end else if (r_t >= MOD1) begin
            w_red = MODW'(r_t - MOD1);
        end else begin
            w_red = r_t[MODW-1:0];
        end
    end

    // Three reduction stages after the product is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done  <= r_stage[2];
            r_stage <= {r_stage[1:0], i_start};
            if (i_start) begin
                r_x <= w_prod;
            end
            if (r_stage[0]) begin
                r_q <= w_qmu[61:31];
            end
            if (r_stage[1]) begin
                r_t <= r_x[31:0] - w_qm;
            end
            if (r_stage[2]) begin
                r_acc <= w_red;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ===== rtl/dspm_div.sv =====
// Restoring divider of the cofactor by a table prime, one quotient bit
// per cycle. Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_div import dspm_pkg::*; #(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_num,
    input  logic [PRIMEW-1:0]      i_den,
    output logic                   o_done,
    output logic                   o_zero_rem,
    output logic [VALUE_WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_q;
    logic [PRIMEW-1:0]      r_r;
    logic [PRIMEW-1:0]      r_den;
    logic [CW-1:0]          r_cnt;
    logic                   r_done;
    logic [PRIMEW:0]        w_t;
    logic                   w_ge;

    // Partial remainder with the next dividend bit.
    always_comb begin
        w_t  = {r_r, r_q[VALUE_WIDTH-1]};
        w_ge = (w_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q   <= i_num;
                r_r   <= '0;
                r_den <= i_den;
                r_cnt <= CW'(VALUE_WIDTH);
            end else if (r_cnt != '0) begin
                r_r   <= w_ge ? PRIMEW'(w_t - {1'b0, r_den}) : w_t[PRIMEW-1:0];
                r_q   <= {r_q[VALUE_WIDTH-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_zero_rem = (r_r == '0);
    assign o_quot     = r_q;

endmodule

// ===== rtl/dspm_datapath.sv =====
// Datapath: sieve flag memory, prime table, factoring and series registers,
// divider and modular multiplier. Uses dspm_pkg, dspm_div and dspm_mulmod.
`timescale 1ns / 1ps

module dspm_datapath import dspm_pkg::*; #(
    parameter int PRIME_TABLE_DEPTH = DEF_PRIME_TABLE_DEPTH,
    parameter int VALUE_WIDTH       = DEF_VALUE_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    input  logic [31:0]     i_base_value,
    input  logic [31:0]     i_power,
    output t_stat           o_stat,
    output logic [MODW-1:0] o_divisor_sum
);

    localparam int AW = $clog2(PRIME_TABLE_DEPTH);
    localparam int KW = $clog2(PRIME_TABLE_DEPTH + 1);
    localparam int VW = VALUE_WIDTH;

    // Memories.
    logic                flag_mem [2**SIEVE_AW];
    logic [PRIMEW-1:0]   tbl_mem  [PRIME_TABLE_DEPTH];
    logic                r_flag_q;
    logic [PRIMEW-1:0]   r_tbl_q;

    // Sieve control.
    logic [SIEVE_AW-1:0] r_i;
    logic [SIEVE_AW:0]   r_j;
    logic [KW-1:0]       r_tcnt;
    logic [SIEVE_AW-1:0] w_isq;

    // Factoring and series registers.
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_p;
    logic [31:0]     r_sq;
    logic [31:0]     r_m;
    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] r_f;
    logic [KW-1:0]   r_k;
    logic [EXPW-1:0] r_e;
    logic [MODW-1:0] r_r;
    logic [MODW-1:0] r_acc;
    logic [MODW-1:0] r_b;
    logic [MODW-1:0] r_num;
    logic [MODW-1:0] r_g;
    logic [MODW-1:0] r_prod;
    logic [MODW-1:0] r_out;
    logic [2:0]      r_mm_dst;
    logic [31:0]     w_tsq;

    // Unit wires.
    logic            w_div_start;
    logic            w_div_done;
    logic            w_div_zero;
    logic [VW-1:0]   w_quot;
    logic            w_mm_start;
    logic            w_mm_done;
    logic [MODW-1:0] w_mm_res;
    logic [31:0]     w_mm_a;
    logic [31:0]     w_mm_b;

    assign w_isq = r_i[7:0] * r_i[7:0];
    assign w_tsq = r_tbl_q * r_tbl_q;

    // Multiplier operand selection.
    always_comb begin
        case (i_cmd.mm_sel)
            MM_P1: begin
                w_mm_a = 32'(r_p);
                w_mm_b = 32'd1;
            end
            MM_FM: begin
                w_mm_a = 32'(r_f);
                w_mm_b = r_m;
            end
            MM_AB: begin
                w_mm_a = 32'(r_acc);
                w_mm_b = 32'(r_b);
            end
            MM_BB: begin
                w_mm_a = 32'(r_b);
                w_mm_b = 32'(r_b);
            end
            MM_NI: begin
                w_mm_a = 32'(r_num);
                w_mm_b = 32'(r_acc);
            end
            MM_PG: begin
                w_mm_a = 32'(r_prod);
                w_mm_b = 32'(r_g);
            end
            default: begin
                w_mm_a = '0;
                w_mm_b = '0;
            end
        endcase
    end

    assign w_mm_start  = (i_cmd.op == OP_MM_GO);
    assign w_div_start = (i_cmd.op == OP_DIV_GO);

    dspm_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_num      (r_rem),
        .i_den      (r_p[PRIMEW-1:0]),
        .o_done     (w_div_done),
        .o_zero_rem (w_div_zero),
        .o_quot     (w_quot)
    );

    dspm_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mm_start),
        .i_a     (w_mm_a),
        .i_b     (w_mm_b),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    // Sieve flag memory: cleared, marked and read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CLR) begin
            flag_mem[r_i] <= 1'b0;
        end else if (i_cmd.op == OP_MARK) begin
            flag_mem[r_j[SIEVE_AW-1:0]] <= 1'b1;
        end
        if (i_cmd.op == OP_FLAG_RD) begin
            r_flag_q <= flag_mem[r_i];
        end
    end

    // Prime table memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ADD_PRIME && r_tcnt < KW'(PRIME_TABLE_DEPTH)) begin
            tbl_mem[r_tcnt[AW-1:0]] <= r_i;
        end
        if (i_cmd.op == OP_TBL_RD) begin
            r_tbl_q <= tbl_mem[r_k[AW-1:0]];
        end
    end

    // Sieve counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i    <= '0;
            r_tcnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_CLR: begin
                    r_i <= (r_i == '1) ? SIEVE_AW'(2) : r_i + 1'b1;
                end
                OP_ADD_PRIME: begin
                    if (r_tcnt < KW'(PRIME_TABLE_DEPTH)) begin
                        r_tcnt <= r_tcnt + 1'b1;
                    end
                    r_j <= {1'b0, w_isq};
                end
                OP_MARK: begin
                    r_j <= r_j + (SIEVE_AW + 1)'(r_i);
                end
                OP_NEXT_I: begin
                    r_i <= r_i + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Factoring and geometric series registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_rem  <= i_base_value[VW-1:0];
                r_m    <= i_power;
                r_prod <= MODW'(1);
                r_k    <= '0;
            end
            OP_ZERO_PROD: begin
                r_prod <= '0;
            end
            OP_LOAD_P: begin
                r_p   <= VW'(r_tbl_q);
                r_sq  <= w_tsq;
                r_cnt <= '0;
            end
            OP_DIV_TAKE: begin
                r_rem <= w_quot;
                r_cnt <= r_cnt + 1'b1;
            end
            OP_NEXT_K: begin
                r_k <= r_k + 1'b1;
            end
            OP_SET_FACT: begin
                r_f <= r_cnt;
                r_e <= EXPW'(r_cnt) * EXPW'(r_m) + EXPW'(1);
            end
            OP_SET_LEFT: begin
                r_f   <= CNTW'(1);
                r_e   <= EXPW'(r_m) + EXPW'(1);
                r_p   <= r_rem;
                r_rem <= VW'(1);
            end
            OP_MM_GO: begin
                r_mm_dst <= i_cmd.mm_sel;
            end
            OP_G_ONE: begin
                r_g <= MODW'(1);
            end
            OP_G_INC: begin
                r_g <= (r_g == MODULUS - 1'b1) ? '0 : r_g + 1'b1;
            end
            OP_POW_NUM: begin
                r_acc <= MODW'(1);
                r_b   <= r_r;
            end
            OP_POW_SHIFT: begin
                r_e <= r_e >> 1;
            end
            OP_NUM_INV: begin
                r_num <= (r_acc == '0) ? MODULUS - 1'b1 : r_acc - 1'b1;
                r_acc <= MODW'(1);
                r_b   <= r_r - 1'b1;
                r_e   <= EXPW'(MODULUS) - EXPW'(2);
            end
            OP_OUT: begin
                r_out <= r_prod;
            end
            default: begin
            end
        endcase

        // Multiplier results land in the register named at its start.
        if (w_mm_done) begin
            case (r_mm_dst)
                MM_P1:   r_r    <= w_mm_res;
                MM_FM:   r_g    <= w_mm_res;
                MM_AB:   r_acc  <= w_mm_res;
                MM_BB:   r_b    <= w_mm_res;
                MM_NI:   r_g    <= w_mm_res;
                MM_PG:   r_prod <= w_mm_res;
                default: r_out  <= r_out;
            endcase
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.i_last   = (r_i == '1);
        o_stat.i_small  = (r_i < SIEVE_AW'(SIEVE_ROOT));
        o_stat.flag_q   = r_flag_q;
        o_stat.mark_end = r_j[SIEVE_AW];
        o_stat.tbl_end  = (r_k == r_tcnt);
        o_stat.sq_gt    = (r_sq > 32'(r_rem));
        o_stat.rem_zero = (r_rem == '0);
        o_stat.m_zero   = (r_m == '0);
        o_stat.rem_gt1  = (r_rem > VW'(1));
        o_stat.div_done = w_div_done;
        o_stat.div_zero = w_div_zero;
        o_stat.cnt_zero = (r_cnt == '0);
        o_stat.mm_done  = w_mm_done;
        o_stat.r_is1    = (r_r == MODW'(1));
        o_stat.r_is0    = (r_r == '0);
        o_stat.e_zero   = (r_e == '0);
        o_stat.e_lsb    = r_e[0];
    end

    assign o_divisor_sum = r_out;

endmodule

// ===== rtl/dspm_ctrl.sv =====
// Controller: state machine that runs the sieve after reset, then factors
// each word and forms the series product. Uses dspm_pkg.
`timescale 1ns / 1ps

module dspm_ctrl import dspm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);

    localparam logic [4:0] ST_CLR       = 5'd0;
    localparam logic [4:0] ST_SV_RD     = 5'd1;
    localparam logic [4:0] ST_SV_CHK    = 5'd2;
    localparam logic [4:0] ST_SV_MARK   = 5'd3;
    localparam logic [4:0] ST_SV_NEXT   = 5'd4;
    localparam logic [4:0] ST_IDLE      = 5'd5;
    localparam logic [4:0] ST_LOAD_CHK  = 5'd6;
    localparam logic [4:0] ST_TBL       = 5'd7;
    localparam logic [4:0] ST_TBL_WAIT  = 5'd8;
    localparam logic [4:0] ST_CMP       = 5'd9;
    localparam logic [4:0] ST_DIV       = 5'd10;
    localparam logic [4:0] ST_DIV_WAIT  = 5'd11;
    localparam logic [4:0] ST_LEFT      = 5'd12;
    localparam logic [4:0] ST_GEO_R     = 5'd13;
    localparam logic [4:0] ST_MM_WAIT   = 5'd14;
    localparam logic [4:0] ST_GEO_CHK   = 5'd15;
    localparam logic [4:0] ST_G_INC     = 5'd16;
    localparam logic [4:0] ST_POW_LOOP  = 5'd17;
    localparam logic [4:0] ST_POW_SQ    = 5'd18;
    localparam logic [4:0] ST_POW_SHIFT = 5'd19;
    localparam logic [4:0] ST_NUM       = 5'd20;
    localparam logic [4:0] ST_G_MUL     = 5'd21;
    localparam logic [4:0] ST_PROD      = 5'd22;
    localparam logic [4:0] ST_AFTER     = 5'd23;
    localparam logic [4:0] ST_FIN       = 5'd24;

    logic [4:0] r_state, n_state;
    logic [4:0] r_ret, n_ret;
    logic       r_inv, n_inv;
    logic       r_left, n_left;
    logic       r_out_valid, n_out_valid;

    // Next state and command.
    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_inv        = r_inv;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd.op     = OP_NOP;
        o_cmd.mm_sel = MM_P1;
        case (r_state)
            ST_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.i_last) n_state = ST_SV_RD;
            end
            ST_SV_RD: begin
                o_cmd.op = OP_FLAG_RD;
                n_state  = ST_SV_CHK;
            end
            ST_SV_CHK: begin
                if (i_stat.flag_q) begin
                    n_state = ST_SV_NEXT;
                end else begin
                    o_cmd.op = OP_ADD_PRIME;
                    n_state  = i_stat.i_small ? ST_SV_MARK : ST_SV_NEXT;
                end
            end
            ST_SV_MARK: begin
                if (i_stat.mark_end) n_state = ST_SV_NEXT;
                else o_cmd.op = OP_MARK;
            end
            ST_SV_NEXT: begin
                if (i_stat.i_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.op = OP_NEXT_I;
                    n_state  = ST_SV_RD;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_left   = 1'b0;
                    n_state  = ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK: begin
                if (i_stat.rem_zero) begin
                    o_cmd.op = OP_ZERO_PROD;
                    n_state  = ST_FIN;
                end else if (i_stat.m_zero) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_TBL;
                end
            end
            ST_TBL: begin
                if (i_stat.tbl_end) begin
                    n_state = ST_LEFT;
                end else begin
                    o_cmd.op = OP_TBL_RD;
                    n_state  = ST_TBL_WAIT;
                end
            end
            ST_TBL_WAIT: begin
                o_cmd.op = OP_LOAD_P;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                n_state = i_stat.sq_gt ? ST_LEFT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    if (i_stat.div_zero) begin
                        o_cmd.op = OP_DIV_TAKE;
                        n_state  = ST_DIV;
                    end else if (!i_stat.cnt_zero) begin
                        o_cmd.op = OP_SET_FACT;
                        n_state  = ST_GEO_R;
                    end else begin
                        o_cmd.op = OP_NEXT_K;
                        n_state  = ST_TBL;
                    end
                end
            end
            ST_LEFT: begin
                if (i_stat.rem_gt1) begin
                    o_cmd.op = OP_SET_LEFT;
                    n_left   = 1'b1;
                    n_state  = ST_GEO_R;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_GEO_R: begin
                o_cmd.op     = OP_MM_GO;
                o_cmd.mm_sel = MM_P1;
                n_ret        = ST_GEO_CHK;
                n_state      = ST_MM_WAIT;
            end
            ST_MM_WAIT: begin
                if (i_stat.mm_done) n_state = r_ret;
            end
            ST_GEO_CHK: begin
                // A residue of one has no inverse of p - 1: the series is e.
                if (i_stat.r_is1) begin
                    o_cmd.op     = OP_MM_GO;
                    o_cmd.mm_sel = MM_FM;
                    n_ret        = ST_G_INC;
                    n_state      = ST_MM_WAIT;
                end else if (i_stat.r_is0) begin
                    o_cmd.op = OP_G_ONE;
                    n_state  = ST_PROD;
                end else begin
                    o_cmd.op = OP_POW_NUM;
                    n_inv    = 1'b0;
                    n_state  = ST_POW_LOOP;
                end
            end
            ST_G_INC: begin
                o_cmd.op = OP_G_INC;
                n_state  = ST_PROD;
            end
            ST_POW_LOOP: begin
                if (i_stat.e_zero) begin
                    n_state = r_inv ? ST_G_MUL : ST_NUM;
                end else if (i_stat.e_lsb) begin
                    o_cmd.op     = OP_MM_GO;
                    o_cmd.mm_sel = MM_AB;
                    n_ret        = ST_POW_SQ;
                    n_state      = ST_MM_WAIT;
                end else begin
                    n_state = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                o_cmd.op     = OP_MM_GO;
                o_cmd.mm_sel = MM_BB;
                n_ret        = ST_POW_SHIFT;
                n_state      = ST_MM_WAIT;
            end
            ST_POW_SHIFT: begin
                o_cmd.op = OP_POW_SHIFT;
                n_state  = ST_POW_LOOP;
            end
            ST_NUM: begin
                o_cmd.op = OP_NUM_INV;
                n_inv    = 1'b1;
                n_state  = ST_POW_LOOP;
            end
            ST_G_MUL: begin
                o_cmd.op     = OP_MM_GO;
                o_cmd.mm_sel = MM_NI;
                n_ret        = ST_PROD;
                n_state      = ST_MM_WAIT;
            end
            ST_PROD: begin
                o_cmd.op     = OP_MM_GO;
                o_cmd.mm_sel = MM_PG;
                n_ret        = ST_AFTER;
                n_state      = ST_MM_WAIT;
            end
            ST_AFTER: begin
                if (r_left) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.op = OP_NEXT_K;
                    n_state  = ST_TBL;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_ret       <= ST_IDLE;
            r_inv       <= 1'b0;
            r_left      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_inv       <= n_inv;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/divisor_sum_of_power_mod_prime.sv =====
// Sum of divisors of n^m modulo 1000000007. After reset a clearing pass of the
// sieve flags and the sieve fill the prime table; no word is taken until then.
// Per word, each table prime tried goes through the one-bit-a-cycle divider,
// and each prime factor takes up to about 140 modular multiplies.
// One word at a time.
`timescale 1ns / 1ps

module divisor_sum_of_power_mod_prime import dspm_pkg::*; #(
    parameter int PRIME_TABLE_DEPTH = DEF_PRIME_TABLE_DEPTH,
    parameter int VALUE_WIDTH       = DEF_VALUE_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [31:0]     i_base_value,
    input  logic [31:0]     i_power,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [MODW-1:0] o_divisor_sum
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencer.
    dspm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid)
    );

    // Storage and arithmetic.
    dspm_datapath #(
        .PRIME_TABLE_DEPTH(PRIME_TABLE_DEPTH),
        .VALUE_WIDTH      (VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_base_value  (i_base_value),
        .i_power       (i_power),
        .o_stat        (w_stat),
        .o_divisor_sum (o_divisor_sum)
    );

endmodule

// ===== rtl/dspm_checker.sv =====
// Port checker of the divisor sum block and its bind to the top level.
// Uses dspm_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "divisor_sum_of_power_mod_prime_macros.svh"

module dspm_checker import dspm_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic [MODW-1:0] o_divisor_sum
);

    // A waiting result word holds.
    `DSPM_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_divisor_sum), "result changed while stalled")

    // Results are fully reduced residues.
    `DSPM_ASSERT(a_out_range, o_valid |-> (o_divisor_sum < MODULUS), "result not reduced")

    // An accepted word always keeps the block busy for the next cycle.
    `DSPM_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready right after accept")

endmodule

bind divisor_sum_of_power_mod_prime dspm_checker u_dspm_checker (.*);
